// File: rtl/core/mmra_pkg.sv
// Shared types and constants for the memory map region allocator.
// Depends on nothing; the allocator top level imports it.
package mmra_pkg;

   localparam int MAX_REGIONS = 64;
   localparam int ADDR_BITS   = 52;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ENTRY_W     = 2 * ADDR_BITS + 2;

   localparam logic [ADDR_BITS-1:0] PAGE_SIZE  = ADDR_BITS'(64'h1000);
   localparam logic [ADDR_BITS-1:0] LARGE_SIZE = ADDR_BITS'(64'h20_0000);
   localparam int PAGE_BITS  = 12;
   localparam int LARGE_BITS = 21;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_ALIGN = 2'd1;
   localparam logic [1:0] OP_PAGE  = 2'd2;
   localparam logic [1:0] OP_LARGE = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NO_FIT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   localparam logic [1:0] TYPE_USED = 2'd0;
   localparam logic [1:0] TYPE_FREE = 2'd1;

   typedef struct packed {
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] size;
      logic [1:0]           kind;
   } entry_type;

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_LOAD     = 15'b000000000000010,
      S_ALIGN_RD = 15'b000000000000100,
      S_ALIGN_WR = 15'b000000000001000,
      S_SCAN_RD  = 15'b000000000010000,
      S_SCAN_CHK = 15'b000000000100000,
      S_SHIFT_RD = 15'b000000001000000,
      S_SHIFT_WR = 15'b000000010000000,
      S_PUT_HEAD = 15'b000000100000000,
      S_PUT_USED = 15'b000001000000000,
      S_PUT_TAIL = 15'b000010000000000,
      S_SUM_INIT = 15'b000100000000000,
      S_SUM_RD   = 15'b001000000000000,
      S_SUM_ACC  = 15'b010000000000000,
      S_DONE     = 15'b100000000000000
   } state_type;

endpackage

// File: rtl/core/mmra_ram.sv
// Single-port synchronous RAM with a registered read port.
// Generic; used by the allocator top level for the region table.
module mmra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// File: rtl/core/memory_map_region_allocator_unit.sv
// Top level of the memory map region allocator: sequencer, table RAM, output register.
// Depends on mmra_pkg and mmra_ram.
// A load writes one entry, an align rewrites each entry, an allocation scans, shifts and
// splits; every operation then sums the free space before the result is issued.
// Every table access goes through the single RAM port; the next request is taken when the
// sequencer is idle. Reset clears the entry count, the sequencer and rsp_tvalid only.
module memory_map_region_allocator_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // region_base[51:0], region_size[103:52], region_type[105:104],
   // request_bytes[157:106], zero fill[159:158]
   input  logic [159:0] req_tdata,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // alloc_address[51:0], highest_free_top[103:52], total_free[155:104],
   // entry_count[162:156], zero fill[167:163]
   output logic [167:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);
   import mmra_pkg::*;

   localparam int NEED_W = ADDR_BITS + 2;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [1:0]            sh_ff, sh_in;
   logic [1:0]            op_ff, op_in;
   logic [1:0]            status_ff, status_in;
   entry_type             load_ff, load_in;
   logic [ADDR_BITS:0]    reqr_ff, reqr_in;
   logic [NEED_W-1:0]     need_ff, need_in;
   logic [ADDR_BITS-1:0]  cur_b_ff, cur_b_in;
   logic [ADDR_BITS-1:0]  cur_s_ff, cur_s_in;
   logic [ADDR_BITS-1:0]  delta_ff, delta_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [ADDR_BITS-1:0]  top_ff, top_in;
   logic [ADDR_BITS-1:0]  total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [167:0]          rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_addr;
   entry_type             mem_wdata, mem_rdata;

   logic [PAGE_BITS-1:0]  a_delta;
   logic [ADDR_BITS-1:0]  a_delta_w;
   logic [LARGE_BITS-1:0] l_delta;
   logic [ADDR_BITS-1:0]  usz;
   logic [ADDR_BITS:0]    top_sum, tot_sum;
   logic [CNT_W:0]        grown;
   logic [CNT_W-1:0]      dst;

   mmra_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_table (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      sh_in        = sh_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      load_in      = load_ff;
      reqr_in      = reqr_ff;
      need_in      = need_ff;
      cur_b_in     = cur_b_ff;
      cur_s_in     = cur_s_ff;
      delta_in     = delta_ff;
      addr_in      = addr_ff;
      top_in       = top_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;
      mem_addr     = idx_ff[IDX_W-1:0];
      mem_wdata    = mem_rdata;

      a_delta   = ~mem_rdata.base[PAGE_BITS-1:0] + PAGE_BITS'(1);
      a_delta_w = ADDR_BITS'(a_delta);
      l_delta   = ~mem_rdata.base[LARGE_BITS-1:0] + LARGE_BITS'(1);
      usz       = (op_ff == OP_PAGE) ? PAGE_SIZE : reqr_ff[ADDR_BITS-1:0];
      top_sum   = {1'b0, mem_rdata.base} + {1'b0, mem_rdata.size};
      tot_sum   = {1'b0, total_ff} + {1'b0, mem_rdata.size};
      grown     = {1'b0, count_ff} + {{(CNT_W-1){1'b0}}, sh_in};
      dst       = (idx_ff - CNT_W'(1)) + {{(CNT_W-2){1'b0}}, sh_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in        = req_tuser;
               status_in    = ST_OK;
               addr_in      = '0;
               load_in.base = req_tdata[51:0];
               load_in.size = {req_tdata[103:56], 4'b0000};
               load_in.kind = req_tdata[105:104];
               reqr_in      = ({1'b0, req_tdata[157:106]} + (ADDR_BITS+1)'(LARGE_SIZE - 1'b1))
                              & ~(ADDR_BITS+1)'(LARGE_SIZE - 1'b1);
               need_in      = (req_tuser == OP_PAGE) ? NEED_W'(PAGE_SIZE)
                              : NEED_W'(reqr_in) + NEED_W'(LARGE_SIZE);
               case (req_tuser)
                  OP_LOAD: begin
                     if (count_ff == CNT_W'(MAX_REGIONS)) begin
                        status_in = ST_FULL;
                        state_in  = S_SUM_INIT;
                     end else begin
                        state_in = S_LOAD;
                     end
                  end
                  OP_ALIGN: begin
                     idx_in   = '0;
                     state_in = S_ALIGN_RD;
                  end
                  default: begin
                     idx_in   = count_ff;
                     state_in = S_SCAN_RD;
                  end
               endcase
            end
         end
         S_LOAD: begin
            mem_we    = 1'b1;
            mem_addr  = count_ff[IDX_W-1:0];
            mem_wdata = load_ff;
            count_in  = count_ff + CNT_W'(1);
            state_in  = S_SUM_INIT;
         end
         S_ALIGN_RD: begin
            state_in = (idx_ff == count_ff) ? S_SUM_INIT : S_ALIGN_WR;
         end
         S_ALIGN_WR: begin
            mem_we         = 1'b1;
            mem_wdata.base = mem_rdata.base + a_delta_w;
            mem_wdata.size = (mem_rdata.size < a_delta_w) ? '0
                             : mem_rdata.size - a_delta_w;
            mem_wdata.size[PAGE_BITS-1:0] = '0;
            mem_wdata.kind = mem_rdata.kind;
            idx_in         = idx_ff + CNT_W'(1);
            state_in       = S_ALIGN_RD;
         end
         S_SCAN_RD: begin
            mem_addr = idx_ff[IDX_W-1:0] - IDX_W'(1);
            if (idx_ff <= CNT_W'(1)) begin
               status_in = ST_NO_FIT;
               state_in  = S_SUM_INIT;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (mem_rdata.kind == TYPE_FREE && {2'b00, mem_rdata.size} >= need_ff) begin
               k_in     = idx_ff - CNT_W'(1);
               cur_b_in = mem_rdata.base;
               cur_s_in = mem_rdata.size;
               delta_in = (op_ff == OP_PAGE) ? '0 : ADDR_BITS'(l_delta);
               sh_in    = (delta_in != '0) ? 2'd2 : 2'd1;
               grown    = {1'b0, count_ff} + {{(CNT_W-1){1'b0}}, sh_in};
               if (grown > (CNT_W+1)'(MAX_REGIONS)) begin
                  status_in = ST_FULL;
                  state_in  = S_SUM_INIT;
               end else begin
                  idx_in   = count_ff;
                  state_in = S_SHIFT_RD;
               end
            end else begin
               idx_in   = idx_ff - CNT_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            mem_addr = idx_ff[IDX_W-1:0] - IDX_W'(1);
            if (idx_ff <= k_ff + CNT_W'(1)) begin
               pos_in   = k_ff;
               state_in = (delta_ff != '0) ? S_PUT_HEAD : S_PUT_USED;
            end else begin
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_addr  = dst[IDX_W-1:0];
            mem_wdata = mem_rdata;
            idx_in    = idx_ff - CNT_W'(1);
            state_in  = S_SHIFT_RD;
         end
         S_PUT_HEAD: begin
            mem_we    = 1'b1;
            mem_addr  = pos_ff[IDX_W-1:0];
            mem_wdata = '{base: cur_b_ff, size: delta_ff, kind: TYPE_FREE};
            cur_b_in  = cur_b_ff + delta_ff;
            cur_s_in  = cur_s_ff - delta_ff;
            pos_in    = pos_ff + CNT_W'(1);
            state_in  = S_PUT_USED;
         end
         S_PUT_USED: begin
            mem_we    = 1'b1;
            mem_addr  = pos_ff[IDX_W-1:0];
            mem_wdata = '{base: cur_b_ff, size: usz, kind: TYPE_USED};
            addr_in   = cur_b_ff;
            cur_b_in  = cur_b_ff + usz;
            cur_s_in  = cur_s_ff - usz;
            pos_in    = pos_ff + CNT_W'(1);
            state_in  = S_PUT_TAIL;
         end
         S_PUT_TAIL: begin
            mem_we    = 1'b1;
            mem_addr  = pos_ff[IDX_W-1:0];
            mem_wdata = '{base: cur_b_ff, size: cur_s_ff, kind: TYPE_FREE};
            count_in  = count_ff + {{(CNT_W-2){1'b0}}, sh_ff};
            state_in  = S_SUM_INIT;
         end
         S_SUM_INIT: begin
            idx_in   = '0;
            top_in   = '0;
            total_in = '0;
            state_in = S_SUM_RD;
         end
         S_SUM_RD: begin
            state_in = (idx_ff == count_ff) ? S_DONE : S_SUM_ACC;
         end
         S_SUM_ACC: begin
            if (mem_rdata.kind == TYPE_FREE) begin
               if (top_sum[ADDR_BITS]) begin
                  top_in = '1;
               end else if (top_sum[ADDR_BITS-1:0] > top_ff) begin
                  top_in = top_sum[ADDR_BITS-1:0];
               end
               total_in = tot_sum[ADDR_BITS] ? '1 : tot_sum[ADDR_BITS-1:0];
            end
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_SUM_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {5'b00000, count_ff, total_ff, top_ff, addr_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      sh_ff       <= sh_in;
      op_ff       <= op_in;
      status_ff   <= status_in;
      load_ff     <= load_in;
      reqr_ff     <= reqr_in;
      need_ff     <= need_in;
      cur_b_ff    <= cur_b_in;
      cur_s_ff    <= cur_s_in;
      delta_ff    <= delta_in;
      addr_ff     <= addr_in;
      top_ff      <= top_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REGIONS))
      else $error("entry count exceeds table depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !mem_we)
      else $error("table written outside a sequence");

   a_tail_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT_TAIL) |=> count_ff > $past(count_ff))
      else $error("split did not grow the table");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_user_ff == ST_OK || rsp_user_ff == ST_NO_FIT
                        || rsp_user_ff == ST_FULL))
      else $error("invalid status code");

endmodule
